[rtl/uv_sphere_mesh_generator_macros.svh]
// assertion macros for the uv sphere mesh generator
// clocked on i_clk, disabled while i_rst_n is low
`ifndef UV_SPHERE_MESH_GENERATOR_MACROS_SVH
`define UV_SPHERE_MESH_GENERATOR_MACROS_SVH

// same-cycle implication
`define USM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define USM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/usm_pkg.sv]
// shared constants, types and functions of the uv sphere mesh generator
// no dependencies
package usm_pkg;

    localparam int FRAC_BITS    = 15;
    localparam int DIV_STEPS    = 32;
    localparam int TEX_SHIFT    = DIV_STEPS - FRAC_BITS;
    localparam int NORM_SHIFT   = 30 - FRAC_BITS;
    localparam int NORM_W       = 33 - NORM_SHIFT;
    localparam int HORNER_STEPS = 4;
    localparam int SIN_LAT      = HORNER_STEPS + 3;
    localparam int SIDE_DEPTH   = SIN_LAT + 2;
    localparam int ITEM_GAP     = 3;
    localparam int LANES        = 4;

    localparam logic [10:0] MAX_RINGS   = 11'd1024;
    localparam logic [10:0] MAX_SECTORS = 11'd1024;
    localparam logic [10:0] MIN_RINGS   = 11'd2;
    localparam logic [10:0] MIN_SECTORS = 11'd1;

    localparam logic [1:0] CFG_RINGS   = 2'd0;
    localparam logic [1:0] CFG_SECTORS = 2'd1;
    localparam logic [1:0] CFG_RADIUS  = 2'd2;
    localparam logic [1:0] CFG_LAYOUT  = 2'd3;

    localparam logic [1:0] LAYOUT_POS = 2'd0;
    localparam logic [1:0] LAYOUT_TEX = 2'd1;

    localparam logic [10:0] RST_RINGS   = 11'd16;
    localparam logic [10:0] RST_SECTORS = 11'd32;
    localparam logic [15:0] RST_RADIUS  = 16'd256;
    localparam logic [1:0]  RST_LAYOUT  = 2'd2;

    localparam logic [30:0]        Q30_ONE   = 31'h4000_0000;
    localparam logic signed [31:0] Q30_ONE_S = 32'sh4000_0000;
    localparam logic signed [63:0] Q30_HALF  = 64'sd536870912;
    localparam logic signed [31:0] K1 = 32'sd1686629713;
    localparam logic signed [31:0] K3 = -32'sd693598668;
    localparam logic signed [31:0] K5 = 32'sd85569298;
    localparam logic signed [31:0] K7 = -32'sd5026992;
    localparam logic signed [31:0] K9 = 32'sd172272;

    localparam logic signed [16:0] POS_MAX  = 17'sd65535;
    localparam logic signed [15:0] NORM_MAX = 16'sd32767;

    typedef struct packed {
        logic [9:0]  rem;
        logic [31:0] feed;
        logic [32:0] quo;
    } t_lane;

    typedef struct packed {
        logic              vld;
        logic [9:0]        ring;
        logic [9:0]        sect;
        t_lane [LANES-1:0] lane;
    } t_cell;

    typedef struct packed {
        logic        tri_ok;
        logic [15:0] tex_u;
        logic [15:0] tex_v;
        logic [19:0] tri_a;
        logic [19:0] tri_b;
        logic [19:0] tri_c;
        logic [19:0] tri_d;
    } t_side;

    function automatic logic signed [31:0] sin_coef(input int step);
        logic signed [31:0] k;
        case (step)
            0:       k = K7;
            1:       k = K5;
            2:       k = K3;
            default: k = K1;
        endcase
        return k;
    endfunction

    // integer part above the divisor is taken out before the chain
    function automatic t_lane lane_init(input logic [9:0] n, input logic [10:0] d,
                                        input logic [31:0] feed);
        t_lane l;
        logic  pre;
        pre    = ({1'b0, n} >= d);
        l.rem  = pre ? 10'({1'b0, n} - d) : n;
        l.feed = feed;
        l.quo  = {32'd0, pre};
        return l;
    endfunction

    function automatic logic signed [16:0] sat_pos(input logic signed [33:0] v);
        logic signed [16:0] o;
        if (v > 34'(POS_MAX)) begin
            o = POS_MAX;
        end else if (v < -34'(POS_MAX)) begin
            o = -POS_MAX;
        end else begin
            o = v[16:0];
        end
        return o;
    endfunction

    function automatic logic signed [15:0] sat_norm(input logic signed [NORM_W-1:0] v);
        logic signed [15:0] o;
        if (v > NORM_W'(NORM_MAX)) begin
            o = NORM_MAX;
        end else if (v < -NORM_W'(NORM_MAX)) begin
            o = -NORM_MAX;
        end else begin
            o = v[15:0];
        end
        return o;
    endfunction

endpackage

[rtl/usm_div_cell.sv]
// one restoring division step on each of the four quotient lanes
// depends on usm_pkg
module usm_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [10:0]   i_div_sec,
    input  logic [10:0]   i_div_ring,
    input  usm_pkg::t_cell i_cell,
    output usm_pkg::t_cell o_cell
);

    logic           r_vld;
    usm_pkg::t_cell r_cell;
    usm_pkg::t_cell n_cell;

    function automatic usm_pkg::t_lane step(input usm_pkg::t_lane l, input logic [10:0] d);
        usm_pkg::t_lane o;
        logic [10:0]    t;
        logic           ge;
        t      = {l.rem, l.feed[31]};
        ge     = (t >= d);
        o.rem  = ge ? 10'(t - d) : t[9:0];
        o.feed = {l.feed[30:0], 1'b0};
        o.quo  = {l.quo[31:0], ge};
        return o;
    endfunction

    always_comb begin
        n_cell = i_cell;
        for (int k = 0; k < usm_pkg::LANES; k++) begin
            n_cell.lane[k] = step(i_cell.lane[k], (k < 2) ? i_div_sec : i_div_ring);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_cell.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    always_comb begin
        o_cell     = r_cell;
        o_cell.vld = r_vld;
    end

endmodule

[rtl/usm_sin.sv]
// pipelined quarter-wave sine of a 32-bit phase, q30 result
// depends on usm_pkg
module usm_sin (
    input  logic               i_clk,
    input  logic [31:0]        i_phase,
    output logic signed [31:0] o_val
);

    localparam int HS = usm_pkg::HORNER_STEPS;

    logic [30:0]        n_x;
    logic [30:0]        r_x1;
    logic               r_neg1;
    logic [61:0]        w_sq;
    logic [30:0]        r_x2;
    logic [30:0]        r_xa;
    logic               r_neg2;
    logic signed [31:0] r_p   [HS];
    logic [30:0]        r_hx  [HS];
    logic [30:0]        r_hx2 [HS];
    logic               r_hn  [HS];
    logic signed [63:0] w_fin;
    logic signed [31:0] w_v;
    logic signed [31:0] w_vc;
    logic signed [31:0] r_out;

    // mirror odd quadrants
    assign n_x = i_phase[30] ? usm_pkg::Q30_ONE - 31'(i_phase[29:0]) : 31'(i_phase[29:0]);

    always_ff @(posedge i_clk) begin
        r_x1   <= n_x;
        r_neg1 <= i_phase[31];
    end

    assign w_sq = 62'(r_x1) * 62'(r_x1);

    always_ff @(posedge i_clk) begin
        r_x2   <= w_sq[60:30];
        r_xa   <= r_x1;
        r_neg2 <= r_neg1;
    end

    for (genvar j = 0; j < HS; j++) begin : g_horner
        logic signed [31:0] p_in;
        logic [30:0]        x_in;
        logic [30:0]        x2_in;
        logic               neg_in;
        logic signed [63:0] prod;
        if (j == 0) begin : g_first
            assign p_in   = usm_pkg::K9;
            assign x_in   = r_xa;
            assign x2_in  = r_x2;
            assign neg_in = r_neg2;
        end else begin : g_next
            assign p_in   = r_p[j-1];
            assign x_in   = r_hx[j-1];
            assign x2_in  = r_hx2[j-1];
            assign neg_in = r_hn[j-1];
        end
        assign prod = p_in * $signed({1'b0, x2_in});
        always_ff @(posedge i_clk) begin
            r_p[j]   <= usm_pkg::sin_coef(j) + $signed(prod[61:30]);
            r_hx[j]  <= x_in;
            r_hx2[j] <= x2_in;
            r_hn[j]  <= neg_in;
        end
    end

    assign w_fin = r_p[HS-1] * $signed({1'b0, r_hx[HS-1]});
    assign w_v   = $signed(w_fin[61:30]);

    always_comb begin
        if (w_v < 0) begin
            w_vc = '0;
        end else if (w_v > usm_pkg::Q30_ONE_S) begin
            w_vc = usm_pkg::Q30_ONE_S;
        end else begin
            w_vc = w_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= r_hn[HS-1] ? -w_vc : w_vc;
    end

    assign o_val = r_out;

endmodule

[rtl/uv_sphere_mesh_generator.sv]
// top level of the uv sphere mesh generator: config, prep, division chain,
// trig pipeline and result sequencing; depends on usm_pkg, usm_div_cell, usm_sin
// and uv_sphere_mesh_generator_macros.svh
//
// A grid point is taken when start is high and busy low; busy then stays high for
// the hold-off set by ITEM_GAP, so no new point enters until it has run out, and
// up to 15 points are in flight. The vertex beat appears on o_strobe after the prep
// register, the division chain, the side-data pipeline and the output register,
// followed directly by the two triangle beats unless the ring is the last one;
// run_last marks the final beat. The hold-off comes from the single result port
// carrying up to three beats per point; latency comes from the 32-cell division
// chain and the 7-stage sine pipeline. Results cannot be held off by the receiver.

`include "uv_sphere_mesh_generator_macros.svh"

module uv_sphere_mesh_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [9:0]         i_ring_index,
    input  logic [9:0]         i_sector_index,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output logic               o_strobe,
    output logic signed [16:0] o_pos_x,
    output logic signed [16:0] o_pos_y,
    output logic signed [16:0] o_pos_z,
    output logic [15:0]        o_tex_u,
    output logic [15:0]        o_tex_v,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z,
    output logic [19:0]        o_tri_first,
    output logic [19:0]        o_tri_second,
    output logic [19:0]        o_tri_third,
    output logic               o_run_last
);

    localparam int NS = usm_pkg::DIV_STEPS;
    localparam int SD = usm_pkg::SIDE_DEPTH;

    typedef enum logic [1:0] {EMIT_NONE, EMIT_TRI_A, EMIT_TRI_B} t_emit;

    // config
    logic [10:0] r_ring_count;
    logic [10:0] r_sector_count;
    logic [15:0] r_radius;
    logic [1:0]  r_layout;
    logic [10:0] w_rings;
    logic [10:0] w_secs;
    logic [10:0] w_rdiv;
    logic [10:0] w_smax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_count   <= usm_pkg::RST_RINGS;
            r_sector_count <= usm_pkg::RST_SECTORS;
            r_radius       <= usm_pkg::RST_RADIUS;
            r_layout       <= usm_pkg::RST_LAYOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                usm_pkg::CFG_RINGS:   r_ring_count   <= i_cfg_data[10:0];
                usm_pkg::CFG_SECTORS: r_sector_count <= i_cfg_data[10:0];
                usm_pkg::CFG_RADIUS:  r_radius       <= i_cfg_data;
                usm_pkg::CFG_LAYOUT:  r_layout       <= i_cfg_data[1:0];
                default:              r_layout       <= r_layout;
            endcase
        end
    end

    assign w_rings = (r_ring_count < usm_pkg::MIN_RINGS) ? usm_pkg::MIN_RINGS :
                     (r_ring_count > usm_pkg::MAX_RINGS) ? usm_pkg::MAX_RINGS : r_ring_count;
    assign w_secs  = (r_sector_count < usm_pkg::MIN_SECTORS) ? usm_pkg::MIN_SECTORS :
                     (r_sector_count > usm_pkg::MAX_SECTORS) ? usm_pkg::MAX_SECTORS :
                     r_sector_count;
    assign w_rdiv  = w_rings - 11'd1;
    assign w_smax  = w_secs - 11'd1;

    // input hold-off
    logic [1:0] r_gap;
    logic       w_accept;

    assign busy     = (r_gap != 2'd0);
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
        end else if (w_accept) begin
            r_gap <= 2'(usm_pkg::ITEM_GAP - 1);
        end else if (r_gap != 2'd0) begin
            r_gap <= r_gap - 2'd1;
        end
    end

    // prep: clamp indices
    logic       r_pv;
    logic [9:0] r_pr;
    logic [9:0] r_ps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pr <= ({1'b0, i_ring_index} > w_rdiv) ? w_rdiv[9:0] : i_ring_index;
        r_ps <= ({1'b0, i_sector_index} > w_smax) ? w_smax[9:0] : i_sector_index;
    end

    // division chain
    usm_pkg::t_cell w_chain [NS+1];

    always_comb begin
        w_chain[0].vld     = r_pv;
        w_chain[0].ring    = r_pr;
        w_chain[0].sect    = r_ps;
        w_chain[0].lane[0] = usm_pkg::lane_init(r_ps, w_secs, '0);
        w_chain[0].lane[1] = usm_pkg::lane_init(r_ps, w_secs,
                                 32'(w_secs[10:1]) << usm_pkg::TEX_SHIFT);
        w_chain[0].lane[2] = usm_pkg::lane_init(r_pr, w_rdiv, '0);
        w_chain[0].lane[3] = usm_pkg::lane_init(r_pr, w_rdiv,
                                 32'(w_rdiv[10:1]) << usm_pkg::TEX_SHIFT);
    end

    for (genvar k = 0; k < NS; k++) begin : g_cell
        usm_div_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_div_sec  (w_secs),
            .i_div_ring (w_rdiv),
            .i_cell     (w_chain[k]),
            .o_cell     (w_chain[k+1])
        );
    end

    // trig
    logic [31:0]        w_th;
    logic [31:0]        w_ph;
    logic signed [31:0] w_st;
    logic signed [31:0] w_ct;
    logic signed [31:0] w_sp;
    logic signed [31:0] w_cp;

    assign w_th = w_chain[NS].lane[0].quo[31:0];
    assign w_ph = w_chain[NS].lane[2].quo[32:1];

    usm_sin u_sin_th (.i_clk(i_clk), .i_phase(w_th), .o_val(w_st));
    usm_sin u_cos_th (.i_clk(i_clk), .i_phase(w_th + 32'h4000_0000), .o_val(w_ct));
    usm_sin u_sin_ph (.i_clk(i_clk), .i_phase(w_ph), .o_val(w_sp));
    usm_sin u_cos_ph (.i_clk(i_clk), .i_phase(w_ph + 32'h4000_0000), .o_val(w_cp));

    logic signed [63:0] w_pcs;
    logic signed [63:0] w_pss;
    logic signed [31:0] r_ux;
    logic signed [31:0] r_uy;
    logic signed [31:0] r_uz;

    assign w_pcs = w_ct * w_sp + usm_pkg::Q30_HALF;
    assign w_pss = w_st * w_sp + usm_pkg::Q30_HALF;

    always_ff @(posedge i_clk) begin
        r_ux <= -$signed(w_pcs[61:30]);
        r_uy <= -w_cp;
        r_uz <= -$signed(w_pss[61:30]);
    end

    // scale and round
    logic signed [63:0]          w_rx;
    logic signed [63:0]          w_ry;
    logic signed [63:0]          w_rz;
    logic signed [32:0]          w_nx;
    logic signed [32:0]          w_ny;
    logic signed [32:0]          w_nz;
    logic signed [16:0]          r_px;
    logic signed [16:0]          r_py;
    logic signed [16:0]          r_pz;
    logic signed [15:0]          r_nx;
    logic signed [15:0]          r_ny;
    logic signed [15:0]          r_nz;
    localparam logic signed [32:0] NHALF = 33'sd1 <<< (usm_pkg::NORM_SHIFT - 1);

    assign w_rx = r_ux * $signed({1'b0, r_radius}) + usm_pkg::Q30_HALF;
    assign w_ry = r_uy * $signed({1'b0, r_radius}) + usm_pkg::Q30_HALF;
    assign w_rz = r_uz * $signed({1'b0, r_radius}) + usm_pkg::Q30_HALF;
    assign w_nx = 33'(r_ux) + NHALF;
    assign w_ny = 33'(r_uy) + NHALF;
    assign w_nz = 33'(r_uz) + NHALF;

    always_ff @(posedge i_clk) begin
        r_px <= usm_pkg::sat_pos($signed(w_rx[63:30]));
        r_py <= usm_pkg::sat_pos($signed(w_ry[63:30]));
        r_pz <= usm_pkg::sat_pos($signed(w_rz[63:30]));
        r_nx <= usm_pkg::sat_norm($signed(w_nx[32:usm_pkg::NORM_SHIFT]));
        r_ny <= usm_pkg::sat_norm($signed(w_ny[32:usm_pkg::NORM_SHIFT]));
        r_nz <= usm_pkg::sat_norm($signed(w_nz[32:usm_pkg::NORM_SHIFT]));
    end

    // side data: texture and triangle indices
    usm_pkg::t_side n_side0;
    usm_pkg::t_side r_side [SD];
    logic           r_svld [SD];
    logic [20:0]    w_rs;
    logic [10:0]    w_sinc;
    logic [9:0]     w_s1;
    logic [9:0]     w_cs;

    assign w_cs   = w_chain[NS].sect;
    assign w_rs   = 21'(w_chain[NS].ring) * 21'(w_secs);
    assign w_sinc = 11'(w_cs) + 11'd1;
    assign w_s1   = (w_sinc < w_secs) ? w_sinc[9:0] : '0;

    always_comb begin
        n_side0.tri_ok = (11'(w_chain[NS].ring) < w_rdiv);
        n_side0.tex_u  = w_chain[NS].lane[1].quo[32:usm_pkg::TEX_SHIFT];
        n_side0.tex_v  = w_chain[NS].lane[3].quo[32:usm_pkg::TEX_SHIFT];
        n_side0.tri_a  = 20'(w_rs + 21'(w_cs));
        n_side0.tri_b  = 20'(w_rs + 21'(w_secs) + 21'(w_cs));
        n_side0.tri_c  = 20'(w_rs + 21'(w_secs) + 21'(w_s1));
        n_side0.tri_d  = 20'(w_rs + 21'(w_s1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SD; k++) begin
                r_svld[k] <= 1'b0;
            end
        end else begin
            r_svld[0] <= w_chain[NS].vld;
            for (int k = 1; k < SD; k++) begin
                r_svld[k] <= r_svld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side0;
        for (int k = 1; k < SD; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // result beats
    t_emit       r_state;
    logic        r_strobe;
    logic        r_last;
    logic [19:0] r_ha;
    logic [19:0] r_hb;
    logic [19:0] r_hc;
    logic [19:0] r_hd;
    logic        w_tex_on;
    logic        w_norm_on;
    usm_pkg::t_side w_top;

    assign w_top     = r_side[SD-1];
    assign w_tex_on  = (r_layout != usm_pkg::LAYOUT_POS);
    assign w_norm_on = (r_layout != usm_pkg::LAYOUT_POS) && (r_layout != usm_pkg::LAYOUT_TEX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= EMIT_NONE;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else if (r_svld[SD-1]) begin
            r_state      <= w_top.tri_ok ? EMIT_TRI_A : EMIT_NONE;
            r_strobe     <= 1'b1;
            r_last       <= !w_top.tri_ok;
            o_pos_x      <= r_px;
            o_pos_y      <= r_py;
            o_pos_z      <= r_pz;
            o_tex_u      <= w_tex_on ? w_top.tex_u : '0;
            o_tex_v      <= w_tex_on ? w_top.tex_v : '0;
            o_norm_x     <= w_norm_on ? r_nx : '0;
            o_norm_y     <= w_norm_on ? r_ny : '0;
            o_norm_z     <= w_norm_on ? r_nz : '0;
            o_tri_first  <= '0;
            o_tri_second <= '0;
            o_tri_third  <= '0;
            r_ha         <= w_top.tri_a;
            r_hb         <= w_top.tri_b;
            r_hc         <= w_top.tri_c;
            r_hd         <= w_top.tri_d;
        end else begin
            case (r_state)
                EMIT_TRI_A: begin
                    r_state      <= EMIT_TRI_B;
                    r_strobe     <= 1'b1;
                    r_last       <= 1'b0;
                    o_tri_first  <= r_ha;
                    o_tri_second <= r_hb;
                    o_tri_third  <= r_hc;
                end
                EMIT_TRI_B: begin
                    r_state      <= EMIT_NONE;
                    r_strobe     <= 1'b1;
                    r_last       <= 1'b1;
                    o_tri_first  <= r_hc;
                    o_tri_second <= r_hd;
                    o_tri_third  <= r_ha;
                end
                default: begin
                    r_state  <= EMIT_NONE;
                    r_strobe <= 1'b0;
                    r_last   <= 1'b0;
                end
            endcase
            o_pos_x  <= '0;
            o_pos_y  <= '0;
            o_pos_z  <= '0;
            o_tex_u  <= '0;
            o_tex_v  <= '0;
            o_norm_x <= '0;
            o_norm_y <= '0;
            o_norm_z <= '0;
        end
    end

    assign o_strobe   = r_strobe;
    assign o_run_last = r_last;

    `USM_ASSERT_NEXT(a_accept_holds_off, start && !busy, busy, "point taken without hold-off")
    `USM_ASSERT_NEXT(a_run_continues, o_strobe && !o_run_last, o_strobe, "run broken early")
    `USM_ASSERT_NOW(a_no_overlap, r_state != EMIT_NONE, !r_svld[SD-1], "vertex during triangles")

endmodule

[sim/uv_sphere_checker.sv]
// checker for the uv sphere mesh generator: predicts vertex and triangle beats
// from accepted grid points and register writes, compares them with o_strobe beats
// depends on usm_pkg for register indexes, layout codes, limits and reset values
module uv_sphere_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [9:0]         i_ring_index,
    input  logic [9:0]         i_sector_index,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               o_strobe,
    input  logic signed [16:0] o_pos_x,
    input  logic signed [16:0] o_pos_y,
    input  logic signed [16:0] o_pos_z,
    input  logic [15:0]        o_tex_u,
    input  logic [15:0]        o_tex_v,
    input  logic signed [15:0] o_norm_x,
    input  logic signed [15:0] o_norm_y,
    input  logic signed [15:0] o_norm_z,
    input  logic [19:0]        o_tri_first,
    input  logic [19:0]        o_tri_second,
    input  logic [19:0]        o_tri_third,
    input  logic               o_run_last,
    output int                 fail_count,
    output int                 pending,
    output int                 beat_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [16:0] px, py, pz;
        logic [15:0] tu, tv;
        logic [15:0] nx, ny, nz;
        logic [19:0] ta, tb, tc;
        logic        last;
    } t_mesh_beat;

    localparam longint ONE_Q30 = 64'sd1 << 30;

    logic [10:0] ring_cfg;
    logic [10:0] sect_cfg;
    logic [15:0] radius_cfg;
    logic [1:0]  layout_cfg;
    t_mesh_beat  beat_q[$];

    initial pending = 0;

    function automatic longint rnd_shr(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clip(longint v, longint lim);
        return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function automatic longint quarter_wave(longint x);
        longint x2, p;
        x2 = (x * x) >>> 30;
        p = 64'sd172272;
        p = -64'sd5026992 + ((p * x2) >>> 30);
        p = 64'sd85569298 + ((p * x2) >>> 30);
        p = -64'sd693598668 + ((p * x2) >>> 30);
        p = 64'sd1686629713 + ((p * x2) >>> 30);
        p = (p * x) >>> 30;
        return p < 0 ? 0 : (p > ONE_Q30 ? ONE_Q30 : p);
    endfunction

    function automatic longint sine_of_phase(logic [31:0] ph);
        longint f, v;
        f = longint'(ph[29:0]);
        v = quarter_wave(ph[30] ? ONE_Q30 - f : f);
        return ph[31] ? -v : v;
    endfunction

    task automatic predict_point(logic [9:0] ring_in, logic [9:0] sect_in);
        longint unsigned rings, secs, r, s, s1, a, b, c, d;
        logic [31:0] th, ph;
        longint st, ct, sp, cp;
        longint u[3];
        t_mesh_beat v, t;
        rings = ring_cfg < usm_pkg::MIN_RINGS ? 2 :
                (ring_cfg > usm_pkg::MAX_RINGS ? 1024 : ring_cfg);
        secs = sect_cfg < usm_pkg::MIN_SECTORS ? 1 :
               (sect_cfg > usm_pkg::MAX_SECTORS ? 1024 : sect_cfg);
        r = ring_in > rings - 1 ? rings - 1 : ring_in;
        s = sect_in > secs - 1 ? secs - 1 : sect_in;
        th = 32'((s << 32) / secs);
        ph = 32'((r << 31) / (rings - 1));
        st = sine_of_phase(th);
        ct = sine_of_phase(th + 32'h4000_0000);
        sp = sine_of_phase(ph);
        cp = sine_of_phase(ph + 32'h4000_0000);
        u[0] = -rnd_shr(ct * sp, 30);
        u[1] = -cp;
        u[2] = -rnd_shr(st * sp, 30);
        v = '0;
        v.px = 17'(clip(rnd_shr(u[0] * longint'(radius_cfg), 30), 65535));
        v.py = 17'(clip(rnd_shr(u[1] * longint'(radius_cfg), 30), 65535));
        v.pz = 17'(clip(rnd_shr(u[2] * longint'(radius_cfg), 30), 65535));
        if (layout_cfg != usm_pkg::LAYOUT_POS) begin
            v.tu = 16'(((s << usm_pkg::FRAC_BITS) + secs / 2) / secs);
            v.tv = 16'(((r << usm_pkg::FRAC_BITS) + (rings - 1) / 2) / (rings - 1));
        end
        if (layout_cfg != usm_pkg::LAYOUT_POS && layout_cfg != usm_pkg::LAYOUT_TEX) begin
            v.nx = 16'(clip(rnd_shr(u[0], 30 - usm_pkg::FRAC_BITS), 32767));
            v.ny = 16'(clip(rnd_shr(u[1], 30 - usm_pkg::FRAC_BITS), 32767));
            v.nz = 16'(clip(rnd_shr(u[2], 30 - usm_pkg::FRAC_BITS), 32767));
        end
        if (r + 1 < rings) begin
            s1 = (s + 1 < secs) ? s + 1 : 0;
            a = r * secs + s;
            b = (r + 1) * secs + s;
            c = (r + 1) * secs + s1;
            d = r * secs + s1;
            beat_q.push_back(v);
            t = '0;
            t.ta = 20'(a);
            t.tb = 20'(b);
            t.tc = 20'(c);
            beat_q.push_back(t);
            t.ta = 20'(c);
            t.tb = 20'(d);
            t.tc = 20'(a);
            t.last = 1'b1;
            beat_q.push_back(t);
        end else begin
            v.last = 1'b1;
            beat_q.push_back(v);
        end
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_mesh_beat e;
        if (!i_rst_n) begin
            ring_cfg   <= usm_pkg::RST_RINGS;
            sect_cfg   <= usm_pkg::RST_SECTORS;
            radius_cfg <= usm_pkg::RST_RADIUS;
            layout_cfg <= usm_pkg::RST_LAYOUT;
            fail_count = 0;
            beat_count = 0;
            pending    = beat_q.size();
        end else begin
            if (o_strobe) begin
                beat_count++;
                if (beat_q.size() == 0) begin
                    $display("%0t unexpected beat, nothing predicted", $time);
                    fail_count++;
                end else begin
                    e = beat_q.pop_front();
                    check_field("pos_x", $signed(e.px), o_pos_x);
                    check_field("pos_y", $signed(e.py), o_pos_y);
                    check_field("pos_z", $signed(e.pz), o_pos_z);
                    check_field("tex_u", e.tu, o_tex_u);
                    check_field("tex_v", e.tv, o_tex_v);
                    check_field("norm_x", $signed(e.nx), o_norm_x);
                    check_field("norm_y", $signed(e.ny), o_norm_y);
                    check_field("norm_z", $signed(e.nz), o_norm_z);
                    check_field("tri_first", e.ta, o_tri_first);
                    check_field("tri_second", e.tb, o_tri_second);
                    check_field("tri_third", e.tc, o_tri_third);
                    check_field("run_last", e.last, o_run_last);
                end
            end
            if (start && !busy) begin
                predict_point(i_ring_index, i_sector_index);
            end
            pending = beat_q.size();
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    usm_pkg::CFG_RINGS:   ring_cfg   <= i_cfg_data[10:0];
                    usm_pkg::CFG_SECTORS: sect_cfg   <= i_cfg_data[10:0];
                    usm_pkg::CFG_RADIUS:  radius_cfg <= i_cfg_data;
                    default:              layout_cfg <= i_cfg_data[1:0];
                endcase
            end
        end
    end

endmodule

[sim/tb.sv]
// testbench top for the uv sphere mesh generator: clock, reset, grid point and
// register stimulus, watchdog and verdict; depends on usm_pkg, uv_sphere_mesh_generator and uv_sphere_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [9:0]         i_ring_index;
    logic [9:0]         i_sector_index;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;
    logic               o_strobe;
    logic signed [16:0] o_pos_x, o_pos_y, o_pos_z;
    logic [15:0]        o_tex_u, o_tex_v;
    logic signed [15:0] o_norm_x, o_norm_y, o_norm_z;
    logic [19:0]        o_tri_first, o_tri_second, o_tri_third;
    logic               o_run_last;
    int                 fail_count;
    int                 pending;
    int                 beat_count;
    int                 idle_cycles;
    int                 points_sent;

    uv_sphere_mesh_generator u_top (.*);
    uv_sphere_checker u_chk (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= 5000) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_point(logic [9:0] r, logic [9:0] s);
        int gap;
        start          <= 1'b1;
        i_ring_index   <= r;
        i_sector_index <= s;
        do @(posedge i_clk); while (busy);
        points_sent++;
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 9) < 8 ? $urandom_range(1, 4) : $urandom_range(10, 60));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_points(int n, int rmax, int smax);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
                send_point(10'($urandom), 10'($urandom));
            end else begin
                send_point(10'($urandom_range(0, rmax)), 10'($urandom_range(0, smax)));
            end
        end
    endtask

    initial begin
        int rc, sc;
        start = 1'b0;
        i_ring_index = '0;
        i_sector_index = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = usm_pkg::CFG_RINGS;
        i_cfg_data = '0;
        idle_cycles = 0;
        points_sent = 0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // poles, seam, clamping at reset settings
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd1023);
        send_point(10'd15, 10'd31);
        send_point(10'd14, 10'd31);
        send_point(10'd7, 10'd8);
        send_point(10'd4, 10'd16);
        send_point(10'h2AA, 10'h155);
        send_point(10'h155, 10'h2AA);

        // below-minimum counts, full radius, position only
        write_reg(usm_pkg::CFG_RINGS, 16'd0);
        write_reg(usm_pkg::CFG_SECTORS, 16'd0);
        write_reg(usm_pkg::CFG_RADIUS, 16'hFFFF);
        write_reg(usm_pkg::CFG_LAYOUT, 16'(usm_pkg::LAYOUT_POS));
        send_point(10'd0, 10'd0);
        send_point(10'd1, 10'd5);
        send_point(10'd1023, 10'd1023);

        // above-maximum counts, zero radius, texture layout
        write_reg(usm_pkg::CFG_RINGS, 16'd2047);
        write_reg(usm_pkg::CFG_SECTORS, 16'd2047);
        write_reg(usm_pkg::CFG_RADIUS, 16'd0);
        write_reg(usm_pkg::CFG_LAYOUT, 16'(usm_pkg::LAYOUT_TEX));
        send_point(10'd1022, 10'd1023);
        send_point(10'd1023, 10'd0);
        send_point(10'd0, 10'd1023);

        // largest grid, unused layout code
        write_reg(usm_pkg::CFG_RINGS, 16'd1024);
        write_reg(usm_pkg::CFG_SECTORS, 16'd1024);
        write_reg(usm_pkg::CFG_RADIUS, 16'hFFFF);
        write_reg(usm_pkg::CFG_LAYOUT, 16'd3);
        send_point(10'd1022, 10'd1023);
        send_point(10'd1023, 10'd1023);
        send_point(10'd511, 10'd256);
        random_points(20, 1023, 1023);

        repeat (6) begin
            rc = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : $urandom_range(2, 40);
            sc = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : $urandom_range(1, 40);
            write_reg(usm_pkg::CFG_RINGS, 16'(rc));
            write_reg(usm_pkg::CFG_SECTORS, 16'(sc));
            write_reg(usm_pkg::CFG_RADIUS, 16'($urandom));
            write_reg(usm_pkg::CFG_LAYOUT, 16'($urandom_range(0, 3)));
            random_points(30, rc > 1023 ? 1023 : rc, sc > 1023 ? 1023 : sc);
        end

        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("covered %0d grid points and %0d beats over several register settings",
                 points_sent, beat_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/usm_pkg.sv
rtl/usm_div_cell.sv
rtl/usm_sin.sv
rtl/uv_sphere_mesh_generator.sv
sim/uv_sphere_checker.sv
sim/tb.sv
